// File: rtl/sync_length_frame_deframer_defines.svh
// assertion macros used by the checker file
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SLFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define SLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/slfd_pkg.sv
package slfd_pkg;

  localparam logic [7:0]  SYNC_BYTE        = 8'h5A;
  localparam logic [7:0]  TAIL_BYTE        = 8'hA5;
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd504;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_LONG = 2'd2,
    KIND_TAIL = 2'd3
  } kind_e;

  typedef enum logic [8:0] {
    PH_HUNT1   = 9'b000000001,
    PH_HUNT2   = 9'b000000010,
    PH_COUNT   = 9'b000000100,
    PH_TYPE    = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_TAIL1   = 9'b010000000,
    PH_TAIL2   = 9'b100000000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  seq_count;
    logic [7:0]  frame_type;
    logic [15:0] payload_len;
  } res_t;

endpackage

// File: rtl/slfd_ifs.sv
interface slfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfd_res_if import slfd_pkg::*;;
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  data_byte;
  logic [7:0]  seq_count;
  logic [7:0]  frame_type;
  logic [15:0] payload_len;

  modport source (output valid, output kind, output data_byte, output seq_count,
                  output frame_type, output payload_len, input ready);
  modport sink   (input valid, input kind, input data_byte, input seq_count,
                  input frame_type, input payload_len, output ready);
endinterface

interface slfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload;

  modport source (output valid, output max_payload, input ready);
  modport sink   (input valid, input max_payload, output ready);
endinterface

// File: rtl/sync_length_frame_deframer.sv
// sync word / length prefixed frame deframer
// rx_if carries one link byte per transfer; res_if carries at most one result per byte:
// a payload byte (kind data), or a frame end (good, length too large, bad tail) with
// the header count, type and declared length attached
// cfg_if writes max_payload; it is always ready and should be used only while the block
// is idle (input and result registers empty)
// a byte in the input register passes through the parse logic into the result register,
// which drives the res_if outputs
// throughput: one byte per cycle while no result waits on a stalled receiver, set by the
// combinational parse step between the input register and the result register
// reset (rst_ni low, async) empties both registers, puts the parser in sync hunt and
// loads max_payload with 504
// a stalled receiver holds the result register; bytes that make no result still pass
// through, and once the input register holds a byte that makes a result, rx_if.ready
// drops until the waiting result is taken
// payload bytes go out before the tail is checked, so the receiver drops them when the
// frame ends with a bad tail
module sync_length_frame_deframer import slfd_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  slfd_rx_if.sink     rx_if,
  slfd_res_if.source  res_if,
  slfd_cfg_if.sink    cfg_if
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        step;
  logic        emit;
  logic        out_space;
  logic        push;
  res_t        step_res;
  res_t        out_res;
  logic [15:0] max_payload_q;

  // config register, written whenever a transfer shows up
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_if.valid) begin
      max_payload_q <= cfg_if.max_payload;
    end
  end

  // input register
  slfd_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_if.valid),
    .ready_o (rx_if.ready),
    .byte_i  (rx_if.rx_byte),
    .take_i  (step),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  // a byte that makes no result moves on regardless of the result side;
  // one that makes a result waits for room in the result register
  assign step = in_valid && (!emit || out_space);
  assign push = step && emit;

  slfd_parser u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (in_byte),
    .max_payload_i (max_payload_q),
    .emit_o        (emit),
    .res_o         (step_res)
  );

  // result register
  slfd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (push),
    .res_i   (step_res),
    .space_o (out_space),
    .valid_o (res_if.valid),
    .ready_i (res_if.ready),
    .res_o   (out_res)
  );

  assign res_if.kind        = out_res.kind;
  assign res_if.data_byte   = out_res.data_byte;
  assign res_if.seq_count   = out_res.seq_count;
  assign res_if.frame_type  = out_res.frame_type;
  assign res_if.payload_len = out_res.payload_len;

endmodule

// File: rtl/slfd_in_reg.sv
module slfd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// File: rtl/slfd_parser.sv
module slfd_parser import slfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] max_payload_i,
  output logic        emit_o,
  output res_t        res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] length_q, length_d;
  logic [15:0] left_q, left_d;
  logic        first_ok_q, first_ok_d;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    type_d     = type_q;
    length_d   = length_q;
    left_d     = left_q;
    first_ok_d = first_ok_q;
    emit_o     = 1'b0;
    res_o.kind        = KIND_DATA;
    res_o.data_byte   = 8'h00;
    res_o.seq_count   = count_q;
    res_o.frame_type  = type_q;
    res_o.payload_len = length_q;

    case (phase_q)
      PH_HUNT2: begin
        phase_d = (byte_i == SYNC_BYTE) ? PH_COUNT : PH_HUNT1;
      end
      PH_COUNT: begin
        count_d = byte_i;
        phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        type_d  = byte_i;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_d = {8'h00, byte_i};
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_d = {byte_i, length_q[7:0]};
        if (length_d > max_payload_i) begin
          phase_d           = PH_HUNT1;
          emit_o            = 1'b1;
          res_o.kind        = KIND_LONG;
          res_o.payload_len = length_d;
        end else begin
          left_d  = length_d;
          phase_d = (length_d == 16'd0) ? PH_TAIL1 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        left_d = left_q - 16'd1;
        if (left_d == 16'd0) begin
          phase_d = PH_TAIL1;
        end
        emit_o          = 1'b1;
        res_o.data_byte = byte_i;
      end
      PH_TAIL1: begin
        first_ok_d = (byte_i == TAIL_BYTE);
        phase_d    = PH_TAIL2;
      end
      PH_TAIL2: begin
        phase_d    = PH_HUNT1;
        emit_o     = 1'b1;
        res_o.kind = (first_ok_q && (byte_i == TAIL_BYTE)) ? KIND_GOOD : KIND_TAIL;
      end
      default: begin
        // first sync hunt, also recovers from any illegal code
        phase_d = (byte_i == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT1;
      count_q    <= 8'h00;
      type_q     <= 8'h00;
      length_q   <= 16'h0000;
      left_q     <= 16'h0000;
      first_ok_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      type_q     <= type_d;
      length_q   <= length_d;
      left_q     <= left_d;
      first_ok_q <= first_ok_d;
    end
  end

endmodule

// File: rtl/slfd_out_reg.sv
module slfd_out_reg import slfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic space_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/slfd_checker.sv
`include "sync_length_frame_deframer_defines.svh"

module slfd_checker import slfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input kind_e       res_kind,
  input logic [7:0]  res_data_byte,
  input logic [7:0]  res_seq_count,
  input logic [7:0]  res_frame_type,
  input logic [15:0] res_payload_len
);

  // a stalled result holds until taken
  `SLFD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(res_kind) && $stable(res_data_byte) && $stable(res_seq_count)
    && $stable(res_frame_type) && $stable(res_payload_len), "result changed while stalled")

  // only payload results carry a data byte
  `SLFD_ASSERT_NOW(a_data_zero, res_valid && (res_kind != KIND_DATA),
    res_data_byte == 8'h00, "frame end result with nonzero data byte")

  // payload bytes and length errors both imply a nonzero declared length
  `SLFD_ASSERT_NOW(a_len_nonzero,
    res_valid && ((res_kind == KIND_DATA) || (res_kind == KIND_LONG)),
    res_payload_len != 16'd0, "payload or length error with zero declared length")

endmodule

bind sync_length_frame_deframer slfd_checker u_slfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid       (res_if.valid),
  .res_ready       (res_if.ready),
  .res_kind        (res_if.kind),
  .res_data_byte   (res_if.data_byte),
  .res_seq_count   (res_if.seq_count),
  .res_frame_type  (res_if.frame_type),
  .res_payload_len (res_if.payload_len)
);

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slfd_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  slfd_rx_if  rx_if ();
  slfd_res_if res_if ();
  slfd_cfg_if cfg_if ();

  sync_length_frame_deframer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_if  (rx_if),
    .res_if (res_if),
    .cfg_if (cfg_if)
  );

  localparam res_t NO_RES = '{KIND_DATA, 8'h00, 8'h00, 8'h00, 16'h0000};

  // parser mirror: header fields and frame position as the block should hold them
  phase_e      parse_ph     = PH_HUNT1;
  logic [7:0]  hdr_count    = 8'h00;
  logic [7:0]  hdr_type     = 8'h00;
  logic [15:0] hdr_len      = 16'h0000;
  logic [15:0] remaining    = 16'h0000;
  bit          tail_ok      = 1'b0;
  logic [15:0] length_limit = MAX_PAYLOAD_RST;

  res_t pending_results [$];
  int   bytes_sent = 0;
  int   err_count  = 0;
  bit   calm       = 1'b0;   // no idling on either side while set

  // directed bytes; rows with a typed result push that instead of the mirror's
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       want;
  } dir_row_t;

  dir_row_t dir_tbl [0:25] = '{
    // sync pair broken by its second byte
    '{8'h5A, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    // three sync bytes: the third is the count, length 505 is one over the reset limit
    '{8'h5A, 1'b0, NO_RES},
    '{8'h5A, 1'b0, NO_RES},
    '{8'h5A, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hF9, 1'b0, NO_RES},
    '{8'h01, 1'b1, '{KIND_LONG, 8'h00, 8'h5A, 8'hFF, 16'h01F9}},
    // good frame with the two payload extremes
    '{8'h5A, 1'b0, NO_RES},
    '{8'h5A, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{KIND_DATA, 8'h00, 8'h00, 8'h00, 16'h0002}},
    '{8'hFF, 1'b1, '{KIND_DATA, 8'hFF, 8'h00, 8'h00, 16'h0002}},
    '{8'hA5, 1'b0, NO_RES},
    '{8'hA5, 1'b1, '{KIND_GOOD, 8'h00, 8'h00, 8'h00, 16'h0002}},
    // empty payload straight into a tail whose second byte is wrong
    '{8'h5A, 1'b0, NO_RES},
    '{8'h5A, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'hA5, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{KIND_TAIL, 8'h00, 8'hFF, 8'h01, 16'h0000}}
  };

  // advance the parser mirror by one byte, returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    bit has_res;
    has_res = 1'b0;
    r = NO_RES;
    case (parse_ph)
      PH_HUNT2: begin
        if (b == SYNC_BYTE) parse_ph = PH_COUNT;
        else parse_ph = PH_HUNT1;
      end
      PH_COUNT: begin
        hdr_count = b;
        parse_ph = PH_TYPE;
      end
      PH_TYPE: begin
        hdr_type = b;
        parse_ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        hdr_len = {8'h00, b};
        parse_ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        hdr_len[15:8] = b;
        if (hdr_len > length_limit) begin
          parse_ph = PH_HUNT1;
          r.kind = KIND_LONG;
          has_res = 1'b1;
        end else begin
          remaining = hdr_len;
          if (hdr_len == 16'h0000) parse_ph = PH_TAIL1;
          else parse_ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        remaining = remaining - 16'd1;
        if (remaining == 16'h0000) parse_ph = PH_TAIL1;
        r.kind = KIND_DATA;
        r.data_byte = b;
        has_res = 1'b1;
      end
      PH_TAIL1: begin
        tail_ok = (b == TAIL_BYTE);
        parse_ph = PH_TAIL2;
      end
      PH_TAIL2: begin
        parse_ph = PH_HUNT1;
        if (tail_ok && b == TAIL_BYTE) r.kind = KIND_GOOD;
        else r.kind = KIND_TAIL;
        has_res = 1'b1;
      end
      default: begin
        if (b == SYNC_BYTE) parse_ph = PH_HUNT2;
        else parse_ph = PH_HUNT1;
      end
    endcase
    if (has_res) begin
      r.seq_count = hdr_count;
      r.frame_type = hdr_type;
      r.payload_len = hdr_len;
    end
    return has_res;
  endfunction

  // one byte transfer on the link side, with an occasional gap ahead of it
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    res_t got;
    if (!calm && $urandom_range(99) < 20) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    if (parse_byte(b, got)) pending_results.push_back(typed ? want : got);
    bytes_sent++;
  endtask

  // stop sending, let every result come back and the pipeline empty out
  task automatic drain_link();
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.max_payload <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    length_limit = v;
  endtask

  // one random frame, or a burst of line noise
  task automatic send_frame();
    int unsigned roll;
    int unsigned n_pay;
    logic [7:0]  b;
    logic [7:0]  flip;
    logic [15:0] len;
    bit          abort;
    roll = $urandom_range(99);
    if (roll < 12) begin
      repeat ($urandom_range(6, 1)) begin
        b = 8'($urandom_range(255));
        if ($urandom_range(2) == 0) b = SYNC_BYTE;
        send_byte(b, 1'b0, NO_RES);
      end
    end else begin
      if (roll < 16) begin
        // lone sync byte, then anything but a second one
        flip = 8'd1 << $urandom_range(7);
        send_byte(SYNC_BYTE, 1'b0, NO_RES);
        send_byte(SYNC_BYTE ^ flip, 1'b0, NO_RES);
      end
      send_byte(SYNC_BYTE, 1'b0, NO_RES);
      send_byte(SYNC_BYTE, 1'b0, NO_RES);
      b = 8'($urandom_range(255));
      send_byte(b, 1'b0, NO_RES);
      b = 8'($urandom_range(255));
      send_byte(b, 1'b0, NO_RES);

      // declared length: mostly short, some at or over the limit, a few long ones
      roll = $urandom_range(99);
      if (roll < 55) begin
        len = 16'($urandom_range((length_limit < 16'd12) ? length_limit : 16'd12));
      end else if (roll < 65) begin
        len = (length_limit <= 16'd40) ? length_limit : 16'($urandom_range(40, 13));
      end else if (roll < 80 && length_limit != 16'hFFFF) begin
        if ($urandom_range(1) == 0) len = length_limit + 16'd1;
        else len = 16'($urandom_range(65535, 32'(length_limit) + 1));
      end else if (roll < 84 && length_limit > 16'd200) begin
        len = 16'($urandom_range((length_limit < 16'd300) ? length_limit : 16'd300, 100));
      end else begin
        len = 16'($urandom_range(65535));
        if (len <= length_limit && len > 16'd300) len = {10'd0, len[5:0]};
      end
      send_byte(len[7:0], 1'b0, NO_RES);
      send_byte(len[15:8], 1'b0, NO_RES);

      if (len <= length_limit) begin
        // now and then the frame just stops partway through the payload
        abort = ($urandom_range(19) == 0);
        n_pay = abort ? $urandom_range(32'(len)) : 32'(len);
        repeat (n_pay) begin
          b = 8'($urandom_range(255));
          send_byte(b, 1'b0, NO_RES);
        end
        if (!abort) begin
          roll = $urandom_range(9);
          flip = 8'($urandom_range(255, 1));
          send_byte((roll == 0 || roll == 2) ? TAIL_BYTE ^ flip : TAIL_BYTE, 1'b0, NO_RES);
          flip = 8'($urandom_range(255, 1));
          send_byte((roll == 1 || roll == 2) ? TAIL_BYTE ^ flip : TAIL_BYTE, 1'b0, NO_RES);
        end
      end
    end
  endtask

  // result side: check each transfer against the oldest expectation, random stalls
  always @(posedge clk) begin : check_results
    res_t seen;
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      seen = '{res_if.kind, res_if.data_byte, res_if.seq_count, res_if.frame_type,
               res_if.payload_len};
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected: kind %0d data %02h count %02h type %02h len %04h",
                 $time, seen.kind, seen.data_byte, seen.seq_count, seen.frame_type,
                 seen.payload_len);
      end else begin
        want = pending_results.pop_front();
        if (seen.kind !== want.kind || seen.data_byte !== want.data_byte ||
            seen.seq_count !== want.seq_count || seen.frame_type !== want.frame_type ||
            seen.payload_len !== want.payload_len) begin
          err_count++;
          $display("%0t: mismatch expected kind %0d data %02h count %02h type %02h len %04h",
                   $time, want.kind, want.data_byte, want.seq_count, want.frame_type,
                   want.payload_len);
          $display("%0t:           actual kind %0d data %02h count %02h type %02h len %04h",
                   $time, seen.kind, seen.data_byte, seen.seq_count, seen.frame_type,
                   seen.payload_len);
        end
      end
    end
    res_if.ready <= calm || ($urandom_range(99) >= 25);
  end

  initial begin : stimulus
    int target;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.max_payload = 16'h0000;
    res_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_byte(dir_tbl[i].rx, dir_tbl[i].typed, dir_tbl[i].want);

    // first stretch runs on the reset limit, then one limit per stretch
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain_link();
        case (p)
          1: write_limit(16'hFFFF);
          2: write_limit(16'h0000);
          3: write_limit(16'($urandom_range(20, 1)));
          4: write_limit(16'($urandom_range(65535)));
          default: write_limit(MAX_PAYLOAD_RST);
        endcase
      end
      calm = (p == 1);
      target = bytes_sent + 230;
      while (bytes_sent < target) send_frame();
    end
    calm = 1'b0;

    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
